[hw/rtl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W     = 7;
   localparam int RSP_DATA_W  = ((WORD_W + DEPTH_W + 7) / 8) * 8;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [DEPTH_W-1:0] depth_type;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_MUL  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // per-cell shift control
   typedef struct packed {
      logic take_prev;   // load from the neighbour nearer the top
      logic take_next;   // load from the neighbour further down
   } cell_ctrl_type;

endpackage

[hw/rtl/pse_cell.sv]
// ----------------------------------------------------------------------------
// pse_cell
// One stack entry; shifts down on push and up on pop.
// ----------------------------------------------------------------------------
module pse_cell (
   input  logic                   clock,
   input  pse_pkg::cell_ctrl_type ctrl,
   input  pse_pkg::word_type      prev_data,
   input  pse_pkg::word_type      next_data,
   output pse_pkg::word_type      data
);
   import pse_pkg::*;

   word_type data_ff;
   word_type data_in;

   always_comb begin
      if (ctrl.take_prev) begin
         data_in = prev_data;
      end else if (ctrl.take_next) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[hw/rtl/pse_alu.sv]
// ----------------------------------------------------------------------------
// pse_alu
// Wrapping 32-bit add, subtract and multiply of the two top entries.
// ----------------------------------------------------------------------------
module pse_alu (
   input  pse_pkg::opcode_type opcode,
   input  pse_pkg::word_type   first,
   input  pse_pkg::word_type   second,
   output pse_pkg::word_type   result
);
   import pse_pkg::*;

   always_comb begin
      case (opcode)
         OP_ADD:  result = first + second;
         OP_SUB:  result = first - second;
         OP_MUL:  result = first * second;
         default: result = second;
      endcase
   end

endmodule

[hw/rtl/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Stack machine for postfix expressions built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One token is taken per clock cycle and its result appears in the output
// register on the next cycle; the input stays ready while that register is
// empty or being drained. The cycle is set by the combinational 32x32
// multiply in the path from the two top cells back into the top cell. The
// stack is a row of STACK_DEPTH cells with the top in cell 0: a push shifts
// every cell down, an operator writes its result to cell 0 and shifts the
// rest up. A push onto a full stack reports overflow and an operator with
// fewer than two entries reports underflow; neither changes the stack.
// No clearing pass is needed after reset.
module postfix_stack_evaluator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // operand_value
   input  logic [1:0]                        req_tuser,  // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pse_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // top_value, stack_depth, zero pad
   output logic [1:0]                        rsp_tuser   // status
);
   import pse_pkg::*;

   opcode_type    opcode;
   word_type      operand;
   logic          take;
   logic          is_push;
   logic          push_ok;
   logic          op_ok;
   status_type    status;
   word_type      alu_result;
   word_type      head_data;
   word_type      new_top;
   cell_ctrl_type head_ctrl;
   cell_ctrl_type body_ctrl;
   word_type      cell_data [STACK_DEPTH];

   count_type     count_ff,      count_in;
   logic          rsp_valid_ff,  rsp_valid_in;
   word_type      rsp_top_ff,    rsp_top_in;
   depth_type     rsp_depth_ff,  rsp_depth_in;
   status_type    rsp_status_ff, rsp_status_in;

   assign opcode     = opcode_type'(req_tuser);
   assign operand    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign is_push    = (opcode == OP_PUSH);

   assign push_ok = take && is_push && (count_ff != count_type'(STACK_DEPTH));
   assign op_ok   = take && !is_push && (count_ff >= count_type'(2));

   always_comb begin
      if (is_push && (count_ff == count_type'(STACK_DEPTH))) begin
         status = ST_OVERFLOW;
      end else if (!is_push && (count_ff < count_type'(2))) begin
         status = ST_UNDERFLOW;
      end else begin
         status = ST_OK;
      end
   end

   pse_alu u_alu (
      .opcode (opcode),
      .first  (cell_data[1]),
      .second (cell_data[0]),
      .result (alu_result)
   );

   assign head_data           = is_push ? operand : alu_result;
   assign head_ctrl.take_prev = push_ok || op_ok;
   assign head_ctrl.take_next = 1'b0;
   assign body_ctrl.take_prev = push_ok;
   assign body_ctrl.take_next = op_ok;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         pse_cell u_cell (
            .clock     (clock),
            .ctrl      (head_ctrl),
            .prev_data (head_data),
            .next_data (cell_data[i+1]),
            .data      (cell_data[i])
         );
      end else if (i == STACK_DEPTH - 1) begin : g_tail
         pse_cell u_cell (
            .clock     (clock),
            .ctrl      (body_ctrl),
            .prev_data (cell_data[i-1]),
            .next_data (cell_data[i]),
            .data      (cell_data[i])
         );
      end else begin : g_body
         pse_cell u_cell (
            .clock     (clock),
            .ctrl      (body_ctrl),
            .prev_data (cell_data[i-1]),
            .next_data (cell_data[i+1]),
            .data      (cell_data[i])
         );
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + count_type'(1);
      end else if (op_ok) begin
         count_in = count_ff - count_type'(1);
      end
   end

   // top as it will stand after this transfer
   always_comb begin
      if (count_in == '0) begin
         new_top = '0;
      end else if (push_ok || op_ok) begin
         new_top = head_data;
      end else begin
         new_top = cell_data[0];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = new_top;
         rsp_depth_in  = depth_type'(count_in);
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_depth_ff, rsp_top_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

[hw/rtl/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator.
// ----------------------------------------------------------------------------
module pse_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pse_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser
);
   import pse_pkg::*;

   logic [WORD_W-1:0]  top;
   logic [DEPTH_W-1:0] depth;

   assign top   = rsp_tdata[WORD_W-1:0];
   assign depth = rsp_tdata[WORD_W+DEPTH_W-1:WORD_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // every input transfer gives a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("input transfer without result");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && depth == '0 |-> top == '0)
      else $error("empty stack shows a nonzero top");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_OVERFLOW |-> depth == DEPTH_W'(STACK_DEPTH))
      else $error("overflow reported on a stack that is not full");

   a_underflow_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_UNDERFLOW |-> depth == DEPTH_W'(0) || depth == DEPTH_W'(1))
      else $error("underflow reported with two or more entries");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the postfix stack evaluator.
// ----------------------------------------------------------------------------
// A stack model inside the bench predicts top, depth and status for every
// token transfer. Each result transfer is checked against the oldest
// prediction. A short table of tokens comes first. It covers the extreme
// operands, wrap-around, underflow on an empty and a one-entry stack, a
// fill to overflow and an operator on a full stack. Random expression walks,
// unwinds, fills and noise follow. The sender works in bursts and the
// receiver stalls on its own pattern, with long hold-offs now and then.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import pse_pkg::*;

   localparam int          RANDOM_TOKENS = 1800;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int unsigned HOLD_AT_A     = 400;
   localparam int unsigned HOLD_AT_B     = 1400;

   typedef struct packed {
      word_type   top;
      depth_type  depth;
      status_type status;
   } stack_result_type;

   typedef struct {
      opcode_type       op;
      word_type         value;
      bit               rand_value;
      int unsigned      reps;
      bit               typed;
      stack_result_type want;
   } token_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic [1:0]            req_tuser  = OP_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // stack model
   word_type      model_stack [STACK_DEPTH];
   int unsigned   model_count = 0;

   stack_result_type expected_results [$];
   int unsigned   tokens_sent  = 0;
   int unsigned   result_count = 0;
   int unsigned   fail_count   = 0;
   int unsigned   cycle_count  = 0;
   int unsigned   burst_left   = 0;
   bit            hold_off_req = 1'b0;
   int unsigned   hold_left    = 0;
   int unsigned   mode_left    = 0;
   int unsigned   rx_mode      = 0;

   // operator rows carry a random, ignored operand
   token_row_type directed_rows [23] = '{
      '{OP_ADD,  32'h0000_0000, 1'b1, 1,  1'b1, '{32'h0000_0000, 7'd0, ST_UNDERFLOW}},
      '{OP_PUSH, 32'h8000_0000, 1'b0, 1,  1'b1, '{32'h8000_0000, 7'd1, ST_OK}},
      '{OP_MUL,  32'h0000_0000, 1'b1, 1,  1'b1, '{32'h8000_0000, 7'd1, ST_UNDERFLOW}},
      '{OP_PUSH, 32'h7fff_ffff, 1'b0, 1,  1'b1, '{32'h7fff_ffff, 7'd2, ST_OK}},
      '{OP_ADD,  32'h0000_0000, 1'b1, 1,  1'b1, '{32'hffff_ffff, 7'd1, ST_OK}},
      '{OP_PUSH, 32'h0000_0001, 1'b0, 1,  1'b1, '{32'h0000_0001, 7'd2, ST_OK}},
      '{OP_SUB,  32'h0000_0000, 1'b1, 1,  1'b1, '{32'hffff_fffe, 7'd1, ST_OK}},
      '{OP_PUSH, 32'h8000_0000, 1'b0, 1,  1'b1, '{32'h8000_0000, 7'd2, ST_OK}},
      '{OP_SUB,  32'h0000_0000, 1'b1, 1,  1'b1, '{32'h7fff_fffe, 7'd1, ST_OK}},
      '{OP_PUSH, 32'h7fff_ffff, 1'b0, 1,  1'b1, '{32'h7fff_ffff, 7'd2, ST_OK}},
      '{OP_MUL,  32'h0000_0000, 1'b1, 1,  1'b0, '0},
      '{OP_PUSH, 32'h0000_0000, 1'b0, 1,  1'b1, '{32'h0000_0000, 7'd2, ST_OK}},
      '{OP_MUL,  32'h0000_0000, 1'b1, 1,  1'b0, '0},
      // fill to the top and keep pushing into a full stack
      '{OP_PUSH, 32'h0000_0000, 1'b1, 70, 1'b0, '0},
      '{OP_PUSH, 32'hffff_ffff, 1'b0, 1,  1'b0, '0},
      // operator on a full stack frees an entry first
      '{OP_ADD,  32'h0000_0000, 1'b1, 1,  1'b0, '0},
      '{OP_MUL,  32'h0000_0000, 1'b1, 4,  1'b0, '0},
      '{OP_SUB,  32'h0000_0000, 1'b1, 4,  1'b0, '0},
      '{OP_ADD,  32'h0000_0000, 1'b1, 54, 1'b0, '0},
      '{OP_SUB,  32'h0000_0000, 1'b1, 1,  1'b0, '0},
      '{OP_PUSH, 32'h7fff_ffff, 1'b0, 1,  1'b0, '0},
      '{OP_PUSH, 32'hffff_ffff, 1'b0, 1,  1'b0, '0},
      '{OP_ADD,  32'h0000_0000, 1'b1, 1,  1'b0, '0}
   };

   postfix_stack_evaluator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic stack_result_type eval_token(input opcode_type op, input word_type val);
      stack_result_type r;
      word_type         first;
      word_type         second;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
         if (model_count >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
         end else begin
            model_stack[model_count] = val;
            model_count++;
         end
      end else if (model_count < 2) begin
         r.status = ST_UNDERFLOW;
      end else begin
         second = model_stack[model_count-1];
         first  = model_stack[model_count-2];
         model_count--;
         case (op)
            OP_ADD:  model_stack[model_count-1] = first + second;
            OP_SUB:  model_stack[model_count-1] = first - second;
            default: model_stack[model_count-1] = first * second;
         endcase
      end
      r.top   = (model_count == 0) ? '0 : model_stack[model_count-1];
      r.depth = depth_type'(model_count);
      return r;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         4:       return 32'h0000_0001;
         5, 6:    return word_type'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   function automatic opcode_type rand_operator();
      return opcode_type'($urandom_range(OP_ADD, OP_MUL));
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // one token transfer, preceded by a random gap, possibly none, when the current burst is spent
   task automatic issue_token(input opcode_type op, input word_type val, input bit typed,
                              input stack_result_type typed_want);
      int unsigned      gap;
      bit               taken;
      stack_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
      end
      predicted = eval_token(op, val);
      expected_results.insert(expected_results.size(), typed ? typed_want : predicted);
      tokens_sent++;
      if (tokens_sent == HOLD_AT_A || tokens_sent == HOLD_AT_B) hold_off_req = 1'b1;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // receiver: long hold-off on request, otherwise a changing stall pattern
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_left    = HOLD_CYCLES;
         hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            2:       rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result transfer: top=%h depth=%0d status=%0d",
                                   rsp_tdata[WORD_W-1:0], rsp_tdata[WORD_W +: DEPTH_W],
                                   rsp_tuser));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[WORD_W-1:0] !== want.top ||
                rsp_tdata[WORD_W +: DEPTH_W] !== want.depth ||
                rsp_tuser !== want.status) begin
               note_failure($sformatf(
                  {"result %0d: expected top=%h depth=%0d status=%0d, ",
                   "got top=%h depth=%0d status=%0d"},
                  result_count, want.top, want.depth, want.status,
                  rsp_tdata[WORD_W-1:0], rsp_tdata[WORD_W +: DEPTH_W], rsp_tuser));
            end
            result_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned kind;
      int unsigned len;
      int unsigned stop_at;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         repeat (directed_rows[r].reps) begin
            issue_token(directed_rows[r].op,
                        directed_rows[r].rand_value ? rand_word() : directed_rows[r].value,
                        directed_rows[r].typed, directed_rows[r].want);
         end
      end
      drain_results();

      stop_at = tokens_sent + RANDOM_TOKENS;
      while (tokens_sent < stop_at) begin
         kind = $urandom_range(0, 19);
         if (kind < 12) begin
            // well-formed expression walk
            len = $urandom_range(2, 30);
            repeat (len) begin
               if (model_count < 2 || (model_count < STACK_DEPTH && $urandom_range(0, 1)))
                  issue_token(OP_PUSH, rand_word(), 1'b0, '0);
               else
                  issue_token(rand_operator(), rand_word(), 1'b0, '0);
            end
         end else if (kind < 15) begin
            // unwind to one entry, then stray operators
            while (model_count >= 2) issue_token(rand_operator(), rand_word(), 1'b0, '0);
            repeat ($urandom_range(1, 3)) issue_token(rand_operator(), rand_word(), 1'b0, '0);
         end else if (kind < 18) begin
            repeat ($urandom_range(1, 10))
               issue_token(opcode_type'($urandom_range(OP_PUSH, OP_MUL)), rand_word(), 1'b0, '0);
         end else if (kind == 18) begin
            while (model_count < STACK_DEPTH) issue_token(OP_PUSH, rand_word(), 1'b0, '0);
            repeat ($urandom_range(1, 4)) issue_token(OP_PUSH, rand_word(), 1'b0, '0);
            repeat ($urandom_range(1, 6)) issue_token(rand_operator(), rand_word(), 1'b0, '0);
         end else begin
            drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
